// ----- rtl/cbps_pkg.sv -----
`default_nettype none

package cbps_pkg;

    // table sizes
    localparam int NUM_CLASSES = 26;
    localparam int CAPACITY    = 64;

    // field widths
    localparam int OP_W     = 2;
    localparam int CLASS_W  = 5;
    localparam int REQ_W    = 16;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 2;
    localparam int BOOST_W  = 32;
    localparam int PRIO_W   = 33;
    localparam int EFF_W    = 34;
    localparam int STAMP_W  = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_ARRIVE = 2'd0;
    localparam logic [OP_W-1:0] OP_BOOST  = 2'd1;
    localparam logic [OP_W-1:0] OP_SERVE  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SERVED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    // one row of the client table
    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [PRIO_W-1:0]  prio;
        logic [STAMP_W-1:0] stamp;
        logic [ID_W-1:0]    id;
    } entry_t;

endpackage

`default_nettype wire

// ----- rtl/cbps_if.sv -----
`default_nettype none

// request channel
interface cbps_req_if
    import cbps_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic [CLASS_W-1:0]        class_id;
    logic signed [REQ_W-1:0]   priority_req;
    logic [ID_W-1:0]           client_id;

    modport source (output valid, output operation, output class_id,
                    output priority_req, output client_id, input ready);
    modport sink   (input valid, input operation, input class_id,
                    input priority_req, input client_id, output ready);
endinterface

// result channel
interface cbps_rsp_if
    import cbps_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic [ID_W-1:0]           served_id;
    logic [CLASS_W-1:0]        served_class;
    logic signed [EFF_W-1:0]   served_priority;

    modport source (output valid, output status, output served_id,
                    output served_class, output served_priority, input ready);
    modport sink   (input valid, input status, input served_id,
                    input served_class, input served_priority, output ready);
endinterface

`default_nettype wire

// ----- rtl/cbps_entry_mem.sv -----
`default_nettype none

module cbps_entry_mem
    import cbps_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [$clog2(CAPACITY)-1:0] wr_addr,
    input  wire entry_t                      wr_data,
    input  wire logic                        rd_en,
    input  wire logic [$clog2(CAPACITY)-1:0] rd_addr,
    output entry_t                           rd_data
);

    entry_t mem [CAPACITY];
    entry_t rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/cbps_boost_mem.sv -----
`default_nettype none

module cbps_boost_mem
    import cbps_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire logic [CLASS_W-1:0]  wr_class,
    input  wire logic [BOOST_W-1:0]  wr_boost,
    input  wire logic                rd_en,
    input  wire logic [CLASS_W-1:0]  rd_class,
    output logic [BOOST_W-1:0]       rd_boost
);

    localparam int BW = $clog2(NUM_CLASSES);

    logic [BOOST_W-1:0]     mem [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] written_reg;
    logic [BOOST_W-1:0]     rd_data_reg;
    logic                   rd_ok_reg;
    logic                   wr_in_range;
    logic                   rd_in_range;

    // classes past the table always read as zero boost
    assign wr_in_range = {1'b0, wr_class} < (CLASS_W+1)'(NUM_CLASSES);
    assign rd_in_range = {1'b0, rd_class} < (CLASS_W+1)'(NUM_CLASSES);

    // written flags stand in for the all-zero reset of the table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_ok_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en && wr_in_range)
            begin
                written_reg[wr_class[BW-1:0]] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= rd_in_range && written_reg[rd_class[BW-1:0]];
            end
        end
    end

    // boost storage
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_in_range)
        begin
            mem[wr_class[BW-1:0]] <= wr_boost;
        end
        if (rd_en && rd_in_range)
        begin
            rd_data_reg <= mem[rd_class[BW-1:0]];
        end
    end

    assign rd_boost = rd_ok_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ----- rtl/cbps_alu.sv -----
`default_nettype none

module cbps_alu
    import cbps_pkg::*;
(
    input  wire logic signed [EFF_W-1:0] a,
    input  wire logic signed [EFF_W-1:0] b,
    input  wire logic                    sub,
    input  wire logic signed [EFF_W-1:0] cmp_val,
    output logic signed [EFF_W-1:0]      sum,
    output logic                         sum_gt,
    output logic                         sum_eq
);

    // shared add/subtract followed by a signed compare
    assign sum    = sub ? (a - b) : (a + b);
    assign sum_gt = sum > cmp_val;
    assign sum_eq = sum == cmp_val;

endmodule

`default_nettype wire

// ----- rtl/class_boost_priority_scheduler_core.sv -----
`default_nettype none

// Priority scheduler over a table of CAPACITY waiting clients in NUM_CLASSES
// classes, with one item in flight at a time (req.ready is high only while
// idle). An arrival scans the valid flags one slot per cycle for the lowest
// free slot and then stores the entry; a full table ends the scan at the
// last slot. A boost reads and then writes the class offset, and any other
// code goes straight to its result. A serve reads the entry table one row per
// cycle through a three-step pipe (row read, class boost read, add and
// compare in the shared unit), then frees the winning slot. A result waits in
// an output register, and the block takes the next item while it waits; a
// second result waits in the sequencer until the first is taken.
module class_boost_priority_scheduler_core
    import cbps_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    cbps_req_if.sink  req,
    cbps_rsp_if.source rsp
);

    localparam int IW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARR_SCAN,
        S_ARR_WRITE,
        S_BST_WRITE,
        S_SRV_SCAN,
        S_SRV_END,
        S_OUT
    } state_t;

    state_t                 state_reg, state_next;
    logic [OP_W-1:0]        op_reg, op_next;
    logic [CLASS_W-1:0]     cls_reg, cls_next;
    logic [REQ_W-1:0]       amt_reg, amt_next;
    logic [ID_W-1:0]        id_reg, id_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [IW-1:0]          slot_reg, slot_next;
    logic [STAMP_W-1:0]     counter_reg, counter_next;
    logic [CAPACITY-1:0]    entry_valid_reg, entry_valid_next;

    // serve pipe
    logic                   t1_reg, t1_next;
    logic                   v1_reg, v1_next;
    logic [IW-1:0]          idx1_reg, idx1_next;
    logic                   t2_reg, t2_next;
    logic                   v2_reg, v2_next;
    logic [IW-1:0]          idx2_reg, idx2_next;
    entry_t                 s2_reg, s2_next;

    // best candidate so far
    logic                   best_found_reg, best_found_next;
    logic [EFF_W-1:0]       best_eff_reg, best_eff_next;
    logic [STAMP_W-1:0]     best_age_reg, best_age_next;
    logic [IW-1:0]          best_idx_reg, best_idx_next;
    logic [ID_W-1:0]        best_id_reg, best_id_next;
    logic [CLASS_W-1:0]     best_cls_reg, best_cls_next;

    // pending result
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [ID_W-1:0]        res_id_reg, res_id_next;
    logic [CLASS_W-1:0]     res_cls_reg, res_cls_next;
    logic [EFF_W-1:0]       res_eff_reg, res_eff_next;

    // output register
    logic                   rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]    rsp_status_reg, rsp_status_next;
    logic [ID_W-1:0]        rsp_id_reg, rsp_id_next;
    logic [CLASS_W-1:0]     rsp_cls_reg, rsp_cls_next;
    logic [EFF_W-1:0]       rsp_eff_reg, rsp_eff_next;

    // memory and shared unit hookup
    logic                   em_wr_en;
    entry_t                 em_wr_data;
    logic                   em_rd_en;
    entry_t                 em_rd_data;
    logic                   bm_wr_en;
    logic [BOOST_W-1:0]     bm_wr_boost;
    logic                   bm_rd_en;
    logic [CLASS_W-1:0]     bm_rd_class;
    logic [BOOST_W-1:0]     bm_rd_boost;
    logic signed [EFF_W-1:0] alu_a, alu_b, alu_sum;
    logic                   alu_sub, alu_gt, alu_eq;

    logic                   req_fire;
    logic                   rsp_free;
    logic [IW-1:0]          cnt_idx;
    logic                   cnt_in_table;
    logic [STAMP_W-1:0]     age;
    logic                   take;
    logic                   sat;

    assign req.ready    = (state_reg == S_IDLE);
    assign req_fire     = req.valid && req.ready;
    assign rsp_free     = !rsp_valid_reg || rsp.ready;
    assign cnt_idx      = cnt_reg[IW-1:0];
    assign cnt_in_table = cnt_reg < CNT_W'(CAPACITY);
    assign age          = counter_reg - s2_reg.stamp;

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = rsp_status_reg;
    assign rsp.served_id       = rsp_id_reg;
    assign rsp.served_class    = rsp_cls_reg;
    assign rsp.served_priority = rsp_eff_reg;

    cbps_entry_mem u_entry_mem (
        .clk     (clk),
        .wr_en   (em_wr_en),
        .wr_addr (slot_reg),
        .wr_data (em_wr_data),
        .rd_en   (em_rd_en),
        .rd_addr (cnt_idx),
        .rd_data (em_rd_data)
    );

    cbps_boost_mem u_boost_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (bm_wr_en),
        .wr_class (cls_reg),
        .wr_boost (bm_wr_boost),
        .rd_en    (bm_rd_en),
        .rd_class (bm_rd_class),
        .rd_boost (bm_rd_boost)
    );

    cbps_alu u_alu (
        .a       (alu_a),
        .b       (alu_b),
        .sub     (alu_sub),
        .cmp_val (best_eff_reg),
        .sum     (alu_sum),
        .sum_gt  (alu_gt),
        .sum_eq  (alu_eq)
    );

    // shared unit operands per state
    always_comb
    begin
        alu_a   = {{(EFF_W-PRIO_W){s2_reg.prio[PRIO_W-1]}}, s2_reg.prio};
        alu_b   = {{(EFF_W-BOOST_W){bm_rd_boost[BOOST_W-1]}}, bm_rd_boost};
        alu_sub = 1'b0;
        case (state_reg)
            S_ARR_WRITE:
            begin
                alu_a   = {{(EFF_W-REQ_W){amt_reg[REQ_W-1]}}, amt_reg};
                alu_sub = 1'b1;
            end
            S_BST_WRITE:
            begin
                alu_a = {{(EFF_W-REQ_W){amt_reg[REQ_W-1]}}, amt_reg};
            end
            default:
            begin
            end
        endcase
    end

    // serve candidate wins on higher priority, then on greater age
    assign take = t2_reg && v2_reg &&
                  (!best_found_reg || alu_gt || (alu_eq && (age > best_age_reg)));

    // boost overflows 32 bits when the top three sum bits disagree
    assign sat = (alu_sum[EFF_W-1] != alu_sum[BOOST_W-1]) ||
                 (alu_sum[EFF_W-2] != alu_sum[BOOST_W-1]);

    // sequencer next state
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        cls_next         = cls_reg;
        amt_next         = amt_reg;
        id_next          = id_reg;
        cnt_next         = cnt_reg;
        slot_next        = slot_reg;
        counter_next     = counter_reg;
        entry_valid_next = entry_valid_reg;
        best_found_next  = best_found_reg;
        best_eff_next    = best_eff_reg;
        best_age_next    = best_age_reg;
        best_idx_next    = best_idx_reg;
        best_id_next     = best_id_reg;
        best_cls_next    = best_cls_reg;
        res_status_next  = res_status_reg;
        res_id_next      = res_id_reg;
        res_cls_next     = res_cls_reg;
        res_eff_next     = res_eff_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_status_next  = rsp_status_reg;
        rsp_id_next      = rsp_id_reg;
        rsp_cls_next     = rsp_cls_reg;
        rsp_eff_next     = rsp_eff_reg;

        em_wr_en    = 1'b0;
        em_wr_data  = '{cls: cls_reg, prio: alu_sum[PRIO_W-1:0],
                        stamp: counter_reg, id: id_reg};
        em_rd_en    = 1'b0;
        bm_wr_en    = 1'b0;
        bm_wr_boost = alu_sum[BOOST_W-1:0];
        bm_rd_en    = 1'b0;
        bm_rd_class = req.class_id;

        // pipe shifts every cycle
        t1_next   = (state_reg == S_SRV_SCAN) && cnt_in_table;
        v1_next   = entry_valid_reg[cnt_idx];
        idx1_next = cnt_idx;
        t2_next   = t1_reg;
        v2_next   = v1_reg;
        idx2_next = idx1_reg;
        s2_next   = em_rd_data;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next         = req.operation;
                    cls_next        = req.class_id;
                    amt_next        = req.priority_req;
                    id_next         = req.client_id;
                    cnt_next        = '0;
                    best_found_next = 1'b0;
                    bm_rd_en        = 1'b1;
                    res_status_next = ST_ACCEPTED;
                    res_id_next     = '0;
                    res_cls_next    = '0;
                    res_eff_next    = '0;
                    case (req.operation)
                        OP_ARRIVE: state_next = S_ARR_SCAN;
                        OP_BOOST:  state_next = S_BST_WRITE;
                        OP_SERVE:  state_next = S_SRV_SCAN;
                        default:   state_next = S_OUT;
                    endcase
                end
            end

            // lowest free slot, one per cycle
            S_ARR_SCAN:
            begin
                if (!entry_valid_reg[cnt_idx])
                begin
                    slot_next  = cnt_idx;
                    state_next = S_ARR_WRITE;
                end
                else if (cnt_reg == CNT_W'(CAPACITY - 1))
                begin
                    res_status_next = ST_FULL;
                    state_next      = S_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // store priority minus class boost
            S_ARR_WRITE:
            begin
                em_wr_en                   = 1'b1;
                entry_valid_next[slot_reg] = 1'b1;
                counter_next               = counter_reg + 1'b1;
                state_next                 = S_OUT;
            end

            // saturating boost update
            S_BST_WRITE:
            begin
                bm_wr_en = 1'b1;
                if (sat)
                begin
                    bm_wr_boost = alu_sum[EFF_W-1] ? {1'b1, {(BOOST_W-1){1'b0}}}
                                                   : {1'b0, {(BOOST_W-1){1'b1}}};
                end
                state_next = S_OUT;
            end

            // pipelined scan of the table
            S_SRV_SCAN:
            begin
                em_rd_en    = cnt_in_table;
                bm_rd_en    = t1_reg;
                bm_rd_class = em_rd_data.cls;
                if (take)
                begin
                    best_found_next = 1'b1;
                    best_eff_next   = alu_sum;
                    best_age_next   = age;
                    best_idx_next   = idx2_reg;
                    best_id_next    = s2_reg.id;
                    best_cls_next   = s2_reg.cls;
                end
                if (cnt_reg == CNT_W'(CAPACITY + 1))
                begin
                    state_next = S_SRV_END;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_SRV_END:
            begin
                if (best_found_reg)
                begin
                    entry_valid_next[best_idx_reg] = 1'b0;
                    res_status_next = ST_SERVED;
                    res_id_next     = best_id_reg;
                    res_cls_next    = best_cls_reg;
                    res_eff_next    = best_eff_reg;
                end
                else
                begin
                    res_status_next = ST_EMPTY;
                end
                state_next = S_OUT;
            end

            // hand the result to the output register
            S_OUT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_id_next     = res_id_reg;
                    rsp_cls_next    = res_cls_reg;
                    rsp_eff_next    = res_eff_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            counter_reg     <= '0;
            entry_valid_reg <= '0;
            t1_reg          <= 1'b0;
            t2_reg          <= 1'b0;
            best_found_reg  <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            counter_reg     <= counter_next;
            entry_valid_reg <= entry_valid_next;
            t1_reg          <= t1_next;
            t2_reg          <= t2_next;
            best_found_reg  <= best_found_next;
            rsp_valid_reg   <= rsp_valid_next;
            cnt_reg         <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        cls_reg        <= cls_next;
        amt_reg        <= amt_next;
        id_reg         <= id_next;
        slot_reg       <= slot_next;
        v1_reg         <= v1_next;
        idx1_reg       <= idx1_next;
        v2_reg         <= v2_next;
        idx2_reg       <= idx2_next;
        s2_reg         <= s2_next;
        best_eff_reg   <= best_eff_next;
        best_age_reg   <= best_age_next;
        best_idx_reg   <= best_idx_next;
        best_id_reg    <= best_id_next;
        best_cls_reg   <= best_cls_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_cls_reg    <= res_cls_next;
        res_eff_reg    <= res_eff_next;
        rsp_status_reg <= rsp_status_next;
        rsp_id_reg     <= rsp_id_next;
        rsp_cls_reg    <= rsp_cls_next;
        rsp_eff_reg    <= rsp_eff_next;
    end

    // the chosen winner is still waiting when it is removed
    a_winner_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRV_END && best_found_reg) |-> entry_valid_reg[best_idx_reg])
        else $error("serve winner slot not valid");

    // an arrival never overwrites a waiting client
    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ARR_WRITE) |-> !entry_valid_reg[slot_reg])
        else $error("arrival into occupied slot");

    // only a stored arrival advances the stamp counter
    a_stamp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_ARR_WRITE) |=> (counter_reg == $past(counter_reg)))
        else $error("arrival counter moved without arrival");

    // only a served result carries client data
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_status_reg != ST_SERVED) |->
            (rsp_id_reg == '0 && rsp_cls_reg == '0 && rsp_eff_reg == '0))
        else $error("non-serve result with client fields");

    // an op code is taken only from an accepted item
    a_op_latched: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRV_SCAN) |-> (op_reg == OP_SERVE))
        else $error("scan without serve item");

endmodule

`default_nettype wire

// ----- tb/sv/cbps_sched_checker.sv -----
`timescale 1ns / 1ps

// watches both channels, predicts each result and compares it with the block
module cbps_sched_checker
    import cbps_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    cbps_req_if       req,
    cbps_rsp_if       rsp,
    output int        mismatches,
    output int        pending,
    output int        items_seen,
    output int        served_seen,
    output int        empty_seen,
    output int        full_seen
);

    localparam logic signed [BOOST_W:0] BOOST_HI = 33'sh0_7FFF_FFFF;
    localparam logic signed [BOOST_W:0] BOOST_LO = 33'sh1_8000_0000;
    localparam int PRINT_CAP = 100;

    typedef struct {
        logic [STATUS_W-1:0]     status;
        logic [ID_W-1:0]         id;
        logic [CLASS_W-1:0]      cls;
        logic signed [EFF_W-1:0] eff;
    } sched_result_t;

    // predicted copy of the client table and class offsets
    logic                      waiting     [CAPACITY];
    logic [CLASS_W-1:0]        entry_cls   [CAPACITY];
    logic signed [PRIO_W-1:0]  stored_prio [CAPACITY];
    logic [STAMP_W-1:0]        entry_stamp [CAPACITY];
    logic [ID_W-1:0]           entry_client[CAPACITY];
    logic signed [BOOST_W-1:0] boost_tab   [NUM_CLASSES];
    logic [STAMP_W-1:0]        next_stamp;

    sched_result_t expected_q[$];
    sched_result_t predicted;

    initial begin
        mismatches  = 0;
        pending     = 0;
        items_seen  = 0;
        served_seen = 0;
        empty_seen  = 0;
        full_seen   = 0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // classes past the table have a fixed zero offset
    function automatic logic signed [BOOST_W-1:0] class_offset(input logic [CLASS_W-1:0] c);
        if (c < NUM_CLASSES)
            return boost_tab[c];
        return '0;
    endfunction

    // apply one item to the predicted table and work out its result
    task automatic predict_schedule(
        input  logic [OP_W-1:0]         op,
        input  logic [CLASS_W-1:0]      cls,
        input  logic signed [REQ_W-1:0] amt,
        input  logic [ID_W-1:0]         id,
        output sched_result_t           res
    );
        int                      slot;
        int                      best;
        logic signed [EFF_W-1:0] eff;
        logic signed [EFF_W-1:0] best_eff;
        logic [STAMP_W-1:0]      age;
        logic [STAMP_W-1:0]      best_age;
        logic signed [BOOST_W:0] sum;
        res.status = ST_ACCEPTED;
        res.id     = '0;
        res.cls    = '0;
        res.eff    = '0;
        best_eff   = '0;
        best_age   = '0;
        case (op)
            OP_ARRIVE: begin
                // lowest free slot takes the arrival
                slot = -1;
                for (int i = CAPACITY - 1; i >= 0; i--)
                    if (!waiting[i])
                        slot = i;
                if (slot < 0) begin
                    res.status = ST_FULL;
                end
                else begin
                    waiting[slot]      = 1'b1;
                    entry_cls[slot]    = cls;
                    stored_prio[slot]  = amt - class_offset(cls);
                    entry_stamp[slot]  = next_stamp;
                    entry_client[slot] = id;
                    next_stamp         = next_stamp + 1'b1;
                end
            end
            OP_BOOST: begin
                // saturating add to the class offset
                if (cls < NUM_CLASSES) begin
                    sum = boost_tab[cls] + amt;
                    if (sum > BOOST_HI)
                        sum = BOOST_HI;
                    else if (sum < BOOST_LO)
                        sum = BOOST_LO;
                    boost_tab[cls] = sum[BOOST_W-1:0];
                end
            end
            OP_SERVE: begin
                // highest effective priority, oldest arrival on a tie, lower slot after that
                best = -1;
                for (int i = 0; i < CAPACITY; i++) begin
                    if (waiting[i]) begin
                        eff = stored_prio[i] + class_offset(entry_cls[i]);
                        age = next_stamp - entry_stamp[i];
                        if (best < 0 || eff > best_eff || (eff == best_eff && age > best_age)) begin
                            best     = i;
                            best_eff = eff;
                            best_age = age;
                        end
                    end
                end
                if (best < 0) begin
                    res.status = ST_EMPTY;
                end
                else begin
                    waiting[best] = 1'b0;
                    res.status    = ST_SERVED;
                    res.id        = entry_client[best];
                    res.cls       = entry_cls[best];
                    res.eff       = best_eff;
                end
            end
            default: ;
        endcase
    endtask

    // compare one accepted result with the oldest prediction
    task automatic check_result();
        sched_result_t want;
        if (expected_q.size() == 0) begin
            report_mismatch("result arrived with nothing outstanding");
            return;
        end
        want = expected_q.pop_front();
        if (rsp.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", rsp.status, want.status));
        if (rsp.served_id !== want.id)
            report_mismatch($sformatf("served_id got %0h want %0h", rsp.served_id, want.id));
        if (rsp.served_class !== want.cls)
            report_mismatch($sformatf("served_class got %0d want %0d",
                                      rsp.served_class, want.cls));
        if (rsp.served_priority !== want.eff)
            report_mismatch($sformatf("served_priority got %0d want %0d",
                                      rsp.served_priority, want.eff));
    endtask

    // results are taken before new items so one cannot match its own prediction
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < CAPACITY; i++)
                waiting[i] = 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++)
                boost_tab[i] = '0;
            next_stamp = '0;
            expected_q.delete();
            pending = 0;
        end
        else begin
            if (rsp.valid && rsp.ready)
                check_result();
            if (req.valid && req.ready) begin
                predict_schedule(req.operation, req.class_id, req.priority_req,
                                 req.client_id, predicted);
                expected_q.push_back(predicted);
                items_seen++;
                if (predicted.status == ST_SERVED)
                    served_seen++;
                if (predicted.status == ST_EMPTY)
                    empty_seen++;
                if (predicted.status == ST_FULL)
                    full_seen++;
            end
            pending = expected_q.size();
        end
    end

endmodule

// ----- tb/sv/class_boost_priority_scheduler_core_tb.sv -----
`timescale 1ns / 1ps

module class_boost_priority_scheduler_core_tb;
    import cbps_pkg::*;

    localparam logic [OP_W-1:0]         OP_UNUSED      = 2'd3;
    localparam logic signed [REQ_W-1:0] REQ_MAX        = 16'sh7FFF;
    localparam logic signed [REQ_W-1:0] REQ_MIN        = 16'sh8000;
    localparam logic [CLASS_W-1:0]      TOP_CLASS      = 5'd31;
    localparam logic [CLASS_W-1:0]      SAT_UP_CLASS   = 5'd3;
    localparam logic [CLASS_W-1:0]      SAT_DOWN_CLASS = 5'd4;
    localparam int RANDOM_PER_PHASE = 350;
    localparam int SAT_STEPS        = 20;
    localparam int HOLD_CYCLES      = 400;
    localparam int QUIET_LIMIT      = 2000;

    logic clk;
    logic rst_n;

    int send_idle;
    int recv_idle;
    int hold_asks;
    int hold_seen;
    int hold_left;
    int quiet;

    int mismatches;
    int pending;
    int items_seen;
    int served_seen;
    int empty_seen;
    int full_seen;

    cbps_req_if req_ch();
    cbps_rsp_if rsp_ch();

    class_boost_priority_scheduler_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    cbps_sched_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .pending     (pending),
        .items_seen  (items_seen),
        .served_seen (served_seen),
        .empty_seen  (empty_seen),
        .full_seen   (full_seen)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        hold_seen = 0;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet <= 0;
        end
        else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // offer one item after an optional gap and wait until it is taken
    task automatic send_item(
        input logic [OP_W-1:0]         op,
        input logic [CLASS_W-1:0]      cls,
        input logic signed [REQ_W-1:0] amt,
        input logic [ID_W-1:0]         id
    );
        if ($urandom_range(99) < send_idle) begin
            req_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= op;
        req_ch.class_id     <= cls;
        req_ch.priority_req <= amt;
        req_ch.client_id    <= id;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // classes lean toward a few so that ties and boosts interact
    function automatic logic [CLASS_W-1:0] pick_class();
        int r;
        r = $urandom_range(99);
        if (r < 40) begin
            case ($urandom_range(2))
                0:       return 5'd0;
                1:       return 5'd1;
                default: return CLASS_W'(NUM_CLASSES - 1);
            endcase
        end
        return CLASS_W'($urandom_range(31));
    endfunction

    // many small values for ties, some extremes, rest anywhere
    function automatic logic signed [REQ_W-1:0] pick_amount();
        int                      r;
        int                      v;
        logic signed [REQ_W-1:0] a;
        r = $urandom_range(99);
        if (r < 40) begin
            v = $urandom_range(6);
            v = v - 3;
            a = REQ_W'(v);
        end
        else if (r < 55) begin
            a = $urandom_range(1) ? REQ_MAX : REQ_MIN;
        end
        else begin
            a = REQ_W'($urandom_range(65535));
        end
        return a;
    endfunction

    // batches that fill, drain or hold the table level
    task automatic random_run(input int count);
        int                      done;
        int                      mode;
        int                      left;
        int                      r;
        int                      arrive_pct;
        int                      serve_pct;
        logic [OP_W-1:0]         op;
        logic [CLASS_W-1:0]      cls;
        logic [ID_W-1:0]         id;
        done = 0;
        while (done < count) begin
            mode = $urandom_range(2);
            left = $urandom_range(80, 20);
            arrive_pct = (mode == 0) ? 45 : (mode == 1) ? 70 : 20;
            serve_pct  = (mode == 0) ? 85 : 88;
            while (left > 0 && done < count) begin
                r = $urandom_range(99);
                if (r < arrive_pct)
                    op = OP_ARRIVE;
                else if (r < serve_pct)
                    op = OP_SERVE;
                else if (r < 98)
                    op = OP_BOOST;
                else
                    op = OP_UNUSED;
                cls = pick_class();
                id  = ID_W'($urandom_range(65535));
                send_item(op, cls, pick_amount(), id);
                if (op != OP_UNUSED && !(op == OP_BOOST && cls >= NUM_CLASSES))
                    done++;
                left--;
            end
        end
    endtask

    // main sequence
    initial begin
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.operation    <= OP_ARRIVE;
        req_ch.class_id     <= '0;
        req_ch.priority_req <= '0;
        req_ch.client_id    <= '0;
        send_idle = 18;
        recv_idle = 47;
        hold_asks = 0;
        quiet     = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty serve, unused code, ignored boosts, extremes and ties
        send_item(OP_SERVE, 5'd0, 16'sd0, 16'h0000);
        send_item(OP_UNUSED, TOP_CLASS, -16'sd1, 16'hFFFF);
        send_item(OP_BOOST, TOP_CLASS, REQ_MAX, 16'h0000);
        send_item(OP_BOOST, CLASS_W'(NUM_CLASSES), REQ_MIN, 16'h0000);
        send_item(OP_ARRIVE, 5'd0, REQ_MIN, 16'h0000);
        send_item(OP_ARRIVE, CLASS_W'(NUM_CLASSES - 1), REQ_MAX, 16'hFFFF);
        send_item(OP_ARRIVE, TOP_CLASS, 16'sd0, 16'h0001);
        send_item(OP_ARRIVE, 5'd1, 16'sd5, 16'h0002);
        send_item(OP_ARRIVE, 5'd1, 16'sd5, 16'h0003);
        send_item(OP_BOOST, 5'd0, REQ_MAX, 16'h0000);
        send_item(OP_BOOST, CLASS_W'(NUM_CLASSES - 1), REQ_MIN, 16'h0000);
        send_item(OP_SERVE, 5'd0, 16'sd0, 16'h0000);
        send_item(OP_SERVE, 5'd0, 16'sd0, 16'h0000);
        // younger arrival in a higher slot, three-way tie at the same level
        send_item(OP_ARRIVE, 5'd0, -16'sd1, 16'h0004);
        repeat (5) send_item(OP_SERVE, 5'd0, 16'sd0, 16'h0000);
        send_item(OP_UNUSED, 5'd0, 16'sd0, 16'h0000);

        random_run(RANDOM_PER_PHASE);

        send_idle = 47;
        recv_idle = 18;
        random_run(RANDOM_PER_PHASE);

        // no idling; long receiver hold-off while items keep coming
        send_idle = 0;
        recv_idle = 0;
        hold_asks++;
        random_run(RANDOM_PER_PHASE);

        // empty the table, fill it past capacity, then push two offsets up and down
        repeat (CAPACITY + 1) send_item(OP_SERVE, 5'd0, 16'sd0, 16'h0000);
        for (int i = 0; i < CAPACITY; i++)
            send_item(OP_ARRIVE, i[0] ? SAT_DOWN_CLASS : SAT_UP_CLASS, pick_amount(),
                      ID_W'(i));
        send_item(OP_ARRIVE, SAT_UP_CLASS, REQ_MAX, 16'hBEEF);
        repeat (SAT_STEPS) send_item(OP_BOOST, SAT_UP_CLASS, REQ_MAX, 16'h0000);
        repeat (SAT_STEPS) send_item(OP_BOOST, SAT_DOWN_CLASS, REQ_MIN, 16'h0000);
        send_item(OP_SERVE, 5'd0, 16'sd0, 16'h0000);
        send_item(OP_ARRIVE, SAT_UP_CLASS, REQ_MIN, 16'h1234);
        repeat (CAPACITY + 1) send_item(OP_SERVE, 5'd0, 16'sd0, 16'h0000);
        req_ch.valid <= 1'b0;

        // let outstanding results drain, then allow for a stray late one
        while (pending != 0) @(posedge clk);
        repeat (CAPACITY + 8) @(posedge clk);

        $display("covered %0d items: %0d clients served, %0d serves on an empty table,",
                 items_seen, served_seen, empty_seen);
        $display("  %0d arrivals dropped at full, runs of large boosts in both directions",
                 full_seen);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
